@@ rtl/pmci_pkg.sv @@
// Shared types, widths and command codes for the plotter motion command interpreter.
// Used by pmci_engine, pmci_steps and plotter_motion_command_interpreter.
`timescale 1ns / 1ps

package pmci_pkg;

  // Field and register widths
  localparam int CMD_W  = 8;
  localparam int EXT_W  = 12;
  localparam int SS_W   = 6;
  localparam int PS_W   = 6;
  localparam int LIFT_W = 8;
  localparam int POS_W  = 16;
  localparam int PEN_W  = 10;
  localparam int STEP_W = 24;
  localparam int STZ_W  = 16;

  // Longest R/L run, counter saturates here
  localparam int MAX_RUN = 255;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  // Move arithmetic widths
  localparam int RUN_DIST_W = PS_W + RUN_W;
  localparam int DIST_W     = ((RUN_DIST_W > POS_W) ? RUN_DIST_W : POS_W) + 1;
  localparam int SUM_W      = DIST_W + 1;
  localparam int DX_W       = SUM_W + 1;

  // x steps are -X_NUM*dx*scale/X_DEN, truncated toward zero
  localparam int X_NUM     = 12;
  localparam int X_DEN     = 10;
  localparam int PEN_SCALE = 10;
  localparam int XSC_W     = SS_W + $clog2(X_NUM);
  localparam int PX_W      = DX_W + XSC_W;
  // reciprocal of X_DEN, exact for any PX_W-bit dividend
  localparam int DIV_SH    = PX_W + 4;
  localparam int MAGIC_W   = DIV_SH - 3;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC =
    MAGIC_W'(((64'd1 << DIV_SH) + 64'(X_DEN) - 64'd1) / 64'(X_DEN));
  localparam int PY_W      = DX_W + SS_W + 1;
  localparam int ZM_W      = SS_W + LIFT_W;

  // Configuration port
  localparam int CFG_W     = EXT_W;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_EXTENT,
    REG_STEP_SCALE,
    REG_PROGRAM_STEP,
    REG_LIFT_STEPS
  } cfg_idx_t;

  localparam logic [EXT_W-1:0]  RST_MAX_EXTENT   = EXT_W'(312);
  localparam logic [SS_W-1:0]   RST_STEP_SCALE   = SS_W'(20);
  localparam logic [PS_W-1:0]   RST_PROGRAM_STEP = PS_W'(6);
  localparam logic [LIFT_W-1:0] RST_LIFT_STEPS   = LIFT_W'(48);

  // Jog keys
  localparam logic [CMD_W-1:0] KEY_LEFT  = "a";
  localparam logic [CMD_W-1:0] KEY_RIGHT = "d";
  localparam logic [CMD_W-1:0] KEY_UP    = "w";
  localparam logic [CMD_W-1:0] KEY_DOWN  = "s";
  localparam logic [CMD_W-1:0] KEY_LIFT  = "q";
  localparam logic [CMD_W-1:0] KEY_LOWER = "e";
  localparam logic [CMD_W-1:0] KEY_MODE  = "m";
  localparam logic [CMD_W-1:0] KEY_HOME  = "o";
  localparam logic [CMD_W-1:0] KEY_ZERO  = "z";
  // Program symbols
  localparam logic [CMD_W-1:0] SYM_PEN_UP   = "U";
  localparam logic [CMD_W-1:0] SYM_PEN_DOWN = "D";
  localparam logic [CMD_W-1:0] SYM_TOP      = "T";
  localparam logic [CMD_W-1:0] SYM_BOTTOM   = "B";
  localparam logic [CMD_W-1:0] SYM_RIGHT    = "R";
  localparam logic [CMD_W-1:0] SYM_LEFT     = "L";

  typedef struct packed {
    logic [EXT_W-1:0]  max_extent;
    logic [SS_W-1:0]   step_scale;
    logic [PS_W-1:0]   program_step;
    logic [LIFT_W-1:0] lift_steps;
  } cfg_t;

  typedef struct packed {
    logic has_res;   // this step produces a result
    logic last;      // this step finishes the current item
  } eng_status_t;

  // One result after the position update, before step scaling
  typedef struct packed {
    logic signed [DX_W-1:0]  dx;
    logic signed [DX_W-1:0]  dy;
    logic                    z_en;
    logic                    z_neg;
    logic                    z_big;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PEN_W-1:0]        pos_z;
    logic                    manual_mode;
    logic                    rejected;
    logic                    final_res;
  } move_res_t;

endpackage

@@ rtl/pmci_engine.sv @@
// Command decode, run tracking and position/pen state; at most one result per step.
// Depends on pmci_pkg.
`timescale 1ns / 1ps

module pmci_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [pmci_pkg::CMD_W-1:0]    cmd,
  input  logic                          eop,
  input  logic                          phase,
  input  logic                          fire,
  input  pmci_pkg::cfg_t                cfg,
  output pmci_pkg::eng_status_t         status,
  output pmci_pkg::move_res_t           res
);
  import pmci_pkg::*;

  localparam logic signed [SUM_W-1:0] POS_HI = SUM_W'((1 <<< (POS_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] POS_LO = ~POS_HI;

  logic signed [POS_W-1:0] pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [PEN_W-1:0]        pen_r, pen_nxt;
  logic                    manual_r, manual_nxt;
  logic [RUN_W-1:0]        run_len_r, run_len_nxt;
  logic                    run_left_r, run_left_nxt;

  logic                    is_run, cmd_left, flush_first, fresh_run;
  logic [RUN_W-1:0]        run_bump, fl_len;
  logic                    fl_left;
  logic [RUN_DIST_W-1:0]   fl_dist;
  logic                    req_move, pen_op, pen_lift, do_mode, do_zero, rej;
  logic signed [DIST_W-1:0] req_dx, req_dy;
  logic signed [SUM_W-1:0]  lim, clx, cly;
  logic signed [DX_W-1:0]   dx_eff, dy_eff;

  // clamp a target into 0..lim in automatic mode
  function automatic logic signed [SUM_W-1:0] clamp_axis(
    input logic signed [POS_W-1:0]  cur,
    input logic signed [DIST_W-1:0] d,
    input logic                     auto_mode,
    input logic signed [SUM_W-1:0]  hi
  );
    logic signed [SUM_W-1:0] sum;
    sum = SUM_W'(cur) + SUM_W'(d);
    if (auto_mode && sum[SUM_W-1]) begin
      sum = '0;
    end else if (auto_mode && (sum > hi)) begin
      sum = hi;
    end
    return sum;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    if (v > POS_HI) begin
      r = POS_W'(POS_HI);
    end else if (v < POS_LO) begin
      r = POS_W'(POS_LO);
    end else begin
      r = POS_W'(v);
    end
    return r;
  endfunction

  // Decode and run handling
  always_comb begin
    is_run      = (cmd == SYM_RIGHT) || (cmd == SYM_LEFT);
    cmd_left    = (cmd == SYM_LEFT);
    flush_first = !phase && (run_len_r != '0) && (!is_run || (cmd_left != run_left_r));
    fresh_run   = !phase && !flush_first && is_run;
    if (run_len_r == '0) begin
      run_bump = RUN_W'(1);
    end else if (run_len_r < RUN_W'(MAX_RUN)) begin
      run_bump = run_len_r + RUN_W'(1);
    end else begin
      run_bump = run_len_r;
    end
    fl_len  = fresh_run ? run_bump : run_len_r;
    fl_left = fresh_run ? cmd_left : run_left_r;
    fl_dist = RUN_DIST_W'(cfg.program_step) * RUN_DIST_W'(fl_len);

    run_len_nxt    = run_len_r;
    run_left_nxt   = run_left_r;
    req_move       = 1'b0;
    req_dx         = '0;
    req_dy         = '0;
    pen_op         = 1'b0;
    pen_lift       = 1'b0;
    do_mode        = 1'b0;
    do_zero        = 1'b0;
    rej            = 1'b0;
    status.has_res = 1'b1;
    status.last    = 1'b1;

    if (flush_first || is_run) begin
      if (flush_first) begin
        // old run goes out first; an opposite symbol starts a new run
        run_len_nxt  = is_run ? RUN_W'(1) : '0;
        run_left_nxt = is_run ? cmd_left : run_left_r;
        status.last  = is_run && !eop;
        req_move     = 1'b1;
      end else if (fresh_run) begin
        run_left_nxt = cmd_left;
        if (eop) begin
          run_len_nxt = '0;
          req_move    = 1'b1;
        end else begin
          run_len_nxt    = run_bump;
          status.has_res = 1'b0;
        end
      end else begin
        // second step: end of program flushes the run just started
        run_len_nxt = '0;
        req_move    = 1'b1;
      end
      req_dx = fl_left ? -DIST_W'(fl_dist) : DIST_W'(fl_dist);
    end else begin
      unique case (cmd)
        KEY_LEFT: begin
          req_move = 1'b1;
          req_dx   = -DIST_W'(1);
        end
        KEY_RIGHT: begin
          req_move = 1'b1;
          req_dx   = DIST_W'(1);
        end
        KEY_UP: begin
          req_move = 1'b1;
          req_dy   = DIST_W'(1);
        end
        KEY_DOWN: begin
          req_move = 1'b1;
          req_dy   = -DIST_W'(1);
        end
        SYM_TOP: begin
          req_move = 1'b1;
          req_dy   = DIST_W'(cfg.program_step);
        end
        SYM_BOTTOM: begin
          req_move = 1'b1;
          req_dy   = -DIST_W'(cfg.program_step);
        end
        KEY_HOME: begin
          req_move = 1'b1;
          req_dx   = -DIST_W'(pos_x_r);
          req_dy   = -DIST_W'(pos_y_r);
        end
        KEY_LIFT, SYM_PEN_UP: begin
          pen_op   = 1'b1;
          pen_lift = 1'b1;
        end
        KEY_LOWER, SYM_PEN_DOWN: begin
          pen_op = 1'b1;
        end
        KEY_MODE: begin
          do_mode = 1'b1;
        end
        KEY_ZERO: begin
          do_zero = 1'b1;
        end
        default: begin
          rej = 1'b1;
        end
      endcase
    end
  end

  // Position, pen and mode update
  always_comb begin
    lim    = SUM_W'(cfg.max_extent);
    clx    = clamp_axis(pos_x_r, req_dx, !manual_r, lim);
    cly    = clamp_axis(pos_y_r, req_dy, !manual_r, lim);
    dx_eff = DX_W'(clx) - DX_W'(pos_x_r);
    dy_eff = DX_W'(cly) - DX_W'(pos_y_r);

    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    pen_nxt    = pen_r;
    manual_nxt = manual_r;
    res        = '0;

    if (req_move) begin
      pos_x_nxt = sat_pos(clx);
      pos_y_nxt = sat_pos(cly);
      res.dx    = dx_eff;
      res.dy    = dy_eff;
    end

    if (pen_op) begin
      if (manual_r) begin
        res.z_en  = 1'b1;
        res.z_neg = !pen_lift;
      end else if (pen_lift && (pen_r == '0)) begin
        pen_nxt   = PEN_W'(PEN_W'(cfg.step_scale) * PEN_W'(PEN_SCALE));
        res.z_en  = 1'b1;
        res.z_big = 1'b1;
      end else if (!pen_lift && (pen_r != '0)) begin
        pen_nxt   = '0;
        res.z_en  = 1'b1;
        res.z_big = 1'b1;
        res.z_neg = 1'b1;
      end else begin
        res.rejected = 1'b1;
      end
    end

    if (do_mode) begin
      manual_nxt = !manual_r;
    end
    if (do_zero) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      pen_nxt   = '0;
    end
    if (rej) begin
      res.rejected = 1'b1;
    end

    res.pos_x       = pos_x_nxt;
    res.pos_y       = pos_y_nxt;
    res.pos_z       = pen_nxt;
    res.manual_mode = manual_nxt;
    res.final_res   = status.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r    <= '0;
      pos_y_r    <= '0;
      pen_r      <= '0;
      manual_r   <= 1'b1;
      run_len_r  <= '0;
      run_left_r <= 1'b0;
    end else if (fire) begin
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      pen_r      <= pen_nxt;
      manual_r   <= manual_nxt;
      run_len_r  <= run_len_nxt;
      run_left_r <= run_left_nxt;
    end
  end

endmodule

@@ rtl/pmci_steps.sv @@
// Motor step scaling pipeline: move distances to x/y/pen step counts, with saturation.
// Three registered stages with valid/stall flow control. Depends on pmci_pkg.
`timescale 1ns / 1ps

module pmci_steps (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  pmci_pkg::move_res_t               res,
  input  pmci_pkg::cfg_t                    cfg,
  output logic                              ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [pmci_pkg::STEP_W-1:0] step_x,
  output logic signed [pmci_pkg::STEP_W-1:0] step_y,
  output logic signed [pmci_pkg::STZ_W-1:0]  step_z,
  output logic signed [pmci_pkg::POS_W-1:0]  pos_x,
  output logic signed [pmci_pkg::POS_W-1:0]  pos_y,
  output logic [pmci_pkg::PEN_W-1:0]         pos_z,
  output logic                              manual_mode,
  output logic                              rejected,
  output logic                              final_res
);
  import pmci_pkg::*;

  localparam int PQ_W = PX_W + MAGIC_W;
  localparam int Q_W  = PQ_W - DIV_SH;
  localparam int QS_W = Q_W + 1;
  localparam logic signed [QS_W-1:0] SX_HI = QS_W'((1 <<< (STEP_W - 1)) - 1);
  localparam logic signed [QS_W-1:0] SX_LO = ~SX_HI;
  localparam logic signed [PY_W-1:0] SY_HI = PY_W'((1 <<< (STEP_W - 1)) - 1);
  localparam logic signed [PY_W-1:0] SY_LO = ~SY_HI;

  typedef struct packed {
    logic [PX_W-1:0]         mag_x;
    logic                    x_neg;
    logic signed [PY_W-1:0]  prod_y;
    logic signed [STZ_W-1:0] step_z;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [PEN_W-1:0]        pos_z;
    logic                    manual_mode;
    logic                    rejected;
    logic                    final_res;
  } prod_t;

  move_res_t               s1_r;
  logic                    s1_v_r;
  prod_t                   s2_r, s2_nxt;
  logic                    s2_v_r;
  logic                    out_v_r;
  logic signed [STEP_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [STZ_W-1:0]  sz_r;
  logic signed [POS_W-1:0]  px_r, py_r;
  logic [PEN_W-1:0]         pz_r;
  logic                     man_r, rej_r, fin_r;

  logic                    out_ready, s2_ready;
  logic signed [DX_W-1:0]  dx_s, dy_s;
  logic [DX_W-1:0]         mag_x;
  logic [XSC_W-1:0]        x_scale;
  logic signed [SS_W:0]    scale_s;
  logic [ZM_W-1:0]         z_mag;
  logic [PQ_W-1:0]         quo;
  logic [Q_W-1:0]          q;
  logic signed [QS_W-1:0]  qs;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;
  assign ready     = !s1_v_r || s2_ready;

  // Stage 2: products
  always_comb begin
    dx_s    = s1_r.dx;
    dy_s    = s1_r.dy;
    mag_x   = dx_s[DX_W-1] ? DX_W'(-dx_s) : DX_W'(dx_s);
    x_scale = XSC_W'(cfg.step_scale) * XSC_W'(X_NUM);
    scale_s = {1'b0, cfg.step_scale};
    z_mag   = s1_r.z_big ? ZM_W'(cfg.step_scale) * ZM_W'(cfg.lift_steps)
                         : ZM_W'(cfg.step_scale);

    s2_nxt.mag_x  = PX_W'(mag_x) * PX_W'(x_scale);
    s2_nxt.x_neg  = !dx_s[DX_W-1];      // x steps run opposite to x distance
    s2_nxt.prod_y = PY_W'(dy_s) * PY_W'(scale_s);
    if (!s1_r.z_en) begin
      s2_nxt.step_z = '0;
    end else if (s1_r.z_neg) begin
      s2_nxt.step_z = -STZ_W'(z_mag);
    end else begin
      s2_nxt.step_z = STZ_W'(z_mag);
    end
    s2_nxt.pos_x       = s1_r.pos_x;
    s2_nxt.pos_y       = s1_r.pos_y;
    s2_nxt.pos_z       = s1_r.pos_z;
    s2_nxt.manual_mode = s1_r.manual_mode;
    s2_nxt.rejected    = s1_r.rejected;
    s2_nxt.final_res   = s1_r.final_res;
  end

  // Stage 3: divide by X_DEN via reciprocal, apply sign, saturate
  always_comb begin
    quo = PQ_W'(s2_r.mag_x) * PQ_W'(DIV_MAGIC);
    q   = quo[PQ_W-1:DIV_SH];
    qs  = s2_r.x_neg ? -QS_W'(q) : QS_W'(q);
    if (qs > SX_HI) begin
      sx_nxt = STEP_W'(SX_HI);
    end else if (qs < SX_LO) begin
      sx_nxt = STEP_W'(SX_LO);
    end else begin
      sx_nxt = STEP_W'(qs);
    end
    if (s2_r.prod_y > SY_HI) begin
      sy_nxt = STEP_W'(SY_HI);
    end else if (s2_r.prod_y < SY_LO) begin
      sy_nxt = STEP_W'(SY_LO);
    end else begin
      sy_nxt = STEP_W'(s2_r.prod_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ready) begin
        s1_v_r <= push;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      s1_r <= res;
    end
    if (s2_ready && s1_v_r) begin
      s2_r <= s2_nxt;
    end
    if (out_ready && s2_v_r) begin
      sx_r  <= sx_nxt;
      sy_r  <= sy_nxt;
      sz_r  <= s2_r.step_z;
      px_r  <= s2_r.pos_x;
      py_r  <= s2_r.pos_y;
      pz_r  <= s2_r.pos_z;
      man_r <= s2_r.manual_mode;
      rej_r <= s2_r.rejected;
      fin_r <= s2_r.final_res;
    end
  end

  assign out_valid   = out_v_r;
  assign step_x      = sx_r;
  assign step_y      = sy_r;
  assign step_z      = sz_r;
  assign pos_x       = px_r;
  assign pos_y       = py_r;
  assign pos_z       = pz_r;
  assign manual_mode = man_r;
  assign rejected    = rej_r;
  assign final_res   = fin_r;

endmodule

@@ rtl/plotter_motion_command_interpreter.sv @@
// Plotter motion command interpreter, top level: input register, config registers,
// engine and step pipeline. Depends on pmci_pkg, pmci_engine and pmci_steps.
`timescale 1ns / 1ps
//
// Takes one command byte per transfer on the in_ channel (valid/stall) and
// delivers motor step results on the out_ channel (valid/stall). An input
// byte gives zero, one or two results; out_final_res marks the last one.
// R/L bytes only extend a pending run and give no result until the run is
// flushed by another byte or by in_end_of_program.
// Throughput: one byte per cycle while out_stall is low; a byte that gives two results
// holds the input until the engine has made both, since the engine updates position
// state once per result. A result passes through the input register, the engine into
// the step stage, the product stage and the output register.
// The step pipeline holds up to three results; when out_stall is high the
// output register holds and the stall backs up stage by stage into in_stall.
// Registers are written with cfg_we/cfg_index/cfg_wdata only while the block is idle,
// which the user must ensure; the block does not enforce it. Reset (rst_n low,
// synchronous) empties the pipeline, sets manual mode, clears position, pen height
// and any pending run, and loads register defaults: max_extent 312, step_scale 20,
// program_step 6, lift_steps 48.
module plotter_motion_command_interpreter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pmci_pkg::CMD_W-1:0]          in_command,
  input  logic                                in_end_of_program,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pmci_pkg::STEP_W-1:0]  out_step_x,
  output logic signed [pmci_pkg::STEP_W-1:0]  out_step_y,
  output logic signed [pmci_pkg::STZ_W-1:0]   out_step_z,
  output logic signed [pmci_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [pmci_pkg::POS_W-1:0]   out_pos_y,
  output logic [pmci_pkg::PEN_W-1:0]          out_pos_z,
  output logic                                out_manual_mode,
  output logic                                out_rejected,
  output logic                                out_final_res,
  input  logic                                cfg_we,
  input  logic [pmci_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pmci_pkg::CFG_W-1:0]          cfg_wdata
);
  import pmci_pkg::*;

  cfg_t               cfg_r;
  logic               inq_v_r;
  logic [CMD_W-1:0]   inq_cmd_r;
  logic               inq_eop_r;
  logic               phase_r;
  logic               fire, in_xfer, s1_ready;
  eng_status_t        eng_st;
  move_res_t          eng_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_extent   <= RST_MAX_EXTENT;
      cfg_r.step_scale   <= RST_STEP_SCALE;
      cfg_r.program_step <= RST_PROGRAM_STEP;
      cfg_r.lift_steps   <= RST_LIFT_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_MAX_EXTENT:   cfg_r.max_extent   <= cfg_wdata[EXT_W-1:0];
        REG_STEP_SCALE:   cfg_r.step_scale   <= cfg_wdata[SS_W-1:0];
        REG_PROGRAM_STEP: cfg_r.program_step <= cfg_wdata[PS_W-1:0];
        REG_LIFT_STEPS:   cfg_r.lift_steps   <= cfg_wdata[LIFT_W-1:0];
        default:          cfg_r.max_extent   <= cfg_r.max_extent;
      endcase
    end
  end

  // Engine steps when it has an item and room for the result (if any)
  assign fire     = inq_v_r && (!eng_st.has_res || s1_ready);
  assign in_stall = inq_v_r && !(fire && eng_st.last);
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (in_xfer) begin
      inq_v_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (fire && eng_st.last) begin
      inq_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (fire) begin
      phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      inq_cmd_r <= in_command;
      inq_eop_r <= in_end_of_program;
    end
  end

  pmci_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (inq_cmd_r),
    .eop    (inq_eop_r),
    .phase  (phase_r),
    .fire   (fire),
    .cfg    (cfg_r),
    .status (eng_st),
    .res    (eng_res)
  );

  pmci_steps u_steps (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (fire && eng_st.has_res),
    .res         (eng_res),
    .cfg         (cfg_r),
    .ready       (s1_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .step_x      (out_step_x),
    .step_y      (out_step_y),
    .step_z      (out_step_z),
    .pos_x       (out_pos_x),
    .pos_y       (out_pos_y),
    .pos_z       (out_pos_z),
    .manual_mode (out_manual_mode),
    .rejected    (out_rejected),
    .final_res   (out_final_res)
  );

`ifndef SYNTH
  a_reset_empties_output : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_rejected_no_steps : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rejected |->
      (out_step_x == '0) && (out_step_y == '0) && (out_step_z == '0))
    else $error("rejected result carries motor steps");

  a_empty_input_no_stall : assert property (@(posedge clk) disable iff (!rst_n)
    !inq_v_r |-> !in_stall)
    else $error("input stalled with empty input register");

  a_second_step_only_mid_item : assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> inq_v_r)
    else $error("second result step pending without an item");
`endif

endmodule

@@ dv/plotter_motion_command_interpreter_tb.sv @@
// Self-checking testbench for plotter_motion_command_interpreter: directed and random
// command streams, scored against an in-bench motion tracker. Depends on pmci_pkg.
`timescale 1ns / 1ps

module plotter_motion_command_interpreter_tb;
  import pmci_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 120;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic signed [STEP_W-1:0] step_x;
    logic signed [STEP_W-1:0] step_y;
    logic signed [STZ_W-1:0]  step_z;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [PEN_W-1:0]         pos_z;
    logic                     manual_mode;
    logic                     rejected;
    logic                     final_res;
  } motion_res_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [CMD_W-1:0]         in_command = '0;
  logic                     in_end_of_program = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [STEP_W-1:0] out_step_x;
  logic signed [STEP_W-1:0] out_step_y;
  logic signed [STZ_W-1:0]  out_step_z;
  logic signed [POS_W-1:0]  out_pos_x;
  logic signed [POS_W-1:0]  out_pos_y;
  logic [PEN_W-1:0]         out_pos_z;
  logic                     out_manual_mode;
  logic                     out_rejected;
  logic                     out_final_res;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_wdata = '0;

  // Shadow of the block: settings and tracked motion state
  int lim_extent, lim_scale, lim_pstep, lim_lift;
  int trk_x, trk_y, trk_pen, trk_run;
  bit trk_manual, trk_left;

  motion_res_t expected_moves[$];
  int          mismatch_count = 0;
  bit          quiet_mode = 1'b0;
  bit          hold_request = 1'b0;

  plotter_motion_command_interpreter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_end_of_program (in_end_of_program),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_step_x        (out_step_x),
    .out_step_y        (out_step_y),
    .out_step_z        (out_step_z),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_pos_z         (out_pos_z),
    .out_manual_mode   (out_manual_mode),
    .out_rejected      (out_rejected),
    .out_final_res     (out_final_res),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #4 clk = ~clk;

  // ---------------- motion tracker ----------------

  function automatic longint sat(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic motion_res_t snapshot(input longint sx, input longint sy,
                                           input longint sz, input bit rej);
    motion_res_t r;
    r.step_x      = STEP_W'(sx);
    r.step_y      = STEP_W'(sy);
    r.step_z      = STZ_W'(sz);
    r.pos_x       = POS_W'(trk_x);
    r.pos_y       = POS_W'(trk_y);
    r.pos_z       = PEN_W'(trk_pen);
    r.manual_mode = trk_manual;
    r.rejected    = rej;
    r.final_res   = 1'b0;
    return r;
  endfunction

  function automatic motion_res_t apply_move(input longint dx, input longint dy);
    longint cx, cy, mx, sx, sy;
    cx = trk_x;
    cy = trk_y;
    mx = lim_extent;
    // automatic mode: raise to 0 first, then lower to max_extent
    if (!trk_manual) begin
      if (cx + dx < 0) dx = -cx;
      if (cy + dy < 0) dy = -cy;
      if (cx + dx > mx) dx = mx - cx;
      if (cy + dy > mx) dy = mx - cy;
    end
    sx = sat((-12 * dx * longint'(lim_scale)) / 10, -8388608, 8388607);
    sy = sat(dy * longint'(lim_scale), -8388608, 8388607);
    trk_x = int'(sat(cx + dx, -32768, 32767));
    trk_y = int'(sat(cy + dy, -32768, 32767));
    return snapshot(sx, sy, 0, 1'b0);
  endfunction

  function automatic motion_res_t apply_pen(input bit lift);
    longint s;
    s = lim_scale;
    if (trk_manual) return snapshot(0, 0, lift ? s : -s, 1'b0);
    if (lift && trk_pen == 0) begin
      trk_pen = (lim_scale * 10) & 'h3FF;
      return snapshot(0, 0, s * lim_lift, 1'b0);
    end
    if (!lift && trk_pen > 0) begin
      trk_pen = 0;
      return snapshot(0, 0, -s * lim_lift, 1'b0);
    end
    return snapshot(0, 0, 0, 1'b1);
  endfunction

  function automatic motion_res_t flush_run();
    longint d;
    d = longint'(lim_pstep) * longint'(trk_run);
    trk_run = 0;
    return apply_move(trk_left ? -d : d, 0);
  endfunction

  function automatic void predict_command(input logic [CMD_W-1:0] cmd, input logic eop);
    motion_res_t res[$];
    bit          is_run, left;
    is_run = (cmd == SYM_RIGHT) || (cmd == SYM_LEFT);
    left   = (cmd == SYM_LEFT);
    if (trk_run != 0 && (!is_run || left != trk_left)) res.push_back(flush_run());
    if (is_run) begin
      if (trk_run == 0) begin
        trk_left = left;
        trk_run  = 1;
      end else if (trk_run < MAX_RUN) begin
        trk_run++;
      end
    end else begin
      case (cmd)
        KEY_LEFT:               res.push_back(apply_move(-1, 0));
        KEY_RIGHT:              res.push_back(apply_move(1, 0));
        KEY_UP:                 res.push_back(apply_move(0, 1));
        KEY_DOWN:               res.push_back(apply_move(0, -1));
        KEY_LIFT, SYM_PEN_UP:   res.push_back(apply_pen(1'b1));
        KEY_LOWER, SYM_PEN_DOWN: res.push_back(apply_pen(1'b0));
        SYM_TOP:                res.push_back(apply_move(0, lim_pstep));
        SYM_BOTTOM:             res.push_back(apply_move(0, -lim_pstep));
        KEY_HOME:               res.push_back(apply_move(-longint'(trk_x), -longint'(trk_y)));
        KEY_MODE: begin
          trk_manual = !trk_manual;
          res.push_back(snapshot(0, 0, 0, 1'b0));
        end
        KEY_ZERO: begin
          trk_x   = 0;
          trk_y   = 0;
          trk_pen = 0;
          res.push_back(snapshot(0, 0, 0, 1'b0));
        end
        default:                res.push_back(snapshot(0, 0, 0, 1'b1));
      endcase
    end
    if (eop && trk_run != 0) res.push_back(flush_run());
    if (res.size() > 0) res[res.size()-1].final_res = 1'b1;
    foreach (res[i]) expected_moves.push_back(res[i]);
  endfunction

  // ---------------- result checking ----------------

  function automatic void check_field(input string name, input logic signed [31:0] want,
                                      input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    motion_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_moves.size() == 0) begin
        $display("%0t unexpected result: expected none, got step_x %0d step_y %0d pos %0d,%0d",
                 $time, out_step_x, out_step_y, out_pos_x, out_pos_y);
        mismatch_count++;
      end else begin
        want = expected_moves.pop_front();
        check_field("step_x", 32'(want.step_x), 32'(out_step_x));
        check_field("step_y", 32'(want.step_y), 32'(out_step_y));
        check_field("step_z", 32'(want.step_z), 32'(out_step_z));
        check_field("pos_x", 32'(want.pos_x), 32'(out_pos_x));
        check_field("pos_y", 32'(want.pos_y), 32'(out_pos_y));
        check_field("pos_z", 32'(want.pos_z), 32'(out_pos_z));
        check_field("manual_mode", 32'(want.manual_mode), 32'(out_manual_mode));
        check_field("rejected", 32'(want.rejected), 32'(out_rejected));
        check_field("final_res", 32'(want.final_res), 32'(out_final_res));
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold on request
  initial begin : receiver
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
        @(posedge clk);
      end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[plotter_motion_command_interpreter] ERROR");
    $finish;
  end

  // ---------------- stimulus helpers ----------------

  // One command transfer; valid stays high on return so a following send
  // in the same step keeps the channel busy.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic eop);
    if (!quiet_mode && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_command        <= cmd;
    in_end_of_program <= eop;
    do @(posedge clk); while (in_stall !== 1'b0);
    predict_command(cmd, eop);
  endtask

  // Flush any open run, drop valid, wait out all results and the pipeline
  task automatic settle_block();
    if (trk_run != 0) send_command(trk_left ? SYM_LEFT : SYM_RIGHT, 1'b1);
    in_valid <= 1'b0;
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input int extent, input int scale, input int pstep,
                               input int lift);
    int vals[4];
    settle_block();
    vals = '{extent, scale, pstep, lift};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_wdata <= CFG_W'(vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    lim_extent = extent;
    lim_scale  = scale;
    lim_pstep  = pstep;
    lim_lift   = lift;
  endtask

  function automatic logic [CMD_W-1:0] pick_symbol(input int k);
    case (k)
      0:       return KEY_LEFT;
      1:       return KEY_RIGHT;
      2:       return KEY_UP;
      3:       return KEY_DOWN;
      4:       return KEY_LIFT;
      5:       return KEY_LOWER;
      6:       return KEY_MODE;
      7:       return KEY_HOME;
      8:       return KEY_ZERO;
      9:       return SYM_PEN_UP;
      10:      return SYM_PEN_DOWN;
      11:      return SYM_TOP;
      default: return SYM_BOTTOM;
    endcase
  endfunction

  // Mostly well-formed program text: runs, moves and pen symbols; some noise bytes
  task automatic run_random(input int count);
    int               sent, len, kind;
    logic [CMD_W-1:0] sym;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_command(CMD_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        sent++;
      end else if (kind < 40) begin
        len = $urandom_range(1, 12);
        sym = $urandom_range(0, 1) ? SYM_LEFT : SYM_RIGHT;
        for (int i = 0; i < len; i++)
          send_command(sym, (i == len - 1) && ($urandom_range(0, 2) == 0));
        sent += len;
      end else begin
        send_command(pick_symbol($urandom_range(0, 12)), $urandom_range(0, 9) == 0);
        sent++;
      end
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_jog_keys();
    send_command(KEY_LEFT, 1'b0);
    send_command(KEY_RIGHT, 1'b0);
    send_command(KEY_UP, 1'b0);
    send_command(KEY_DOWN, 1'b1);
    send_command(KEY_LIFT, 1'b0);
    send_command(KEY_LOWER, 1'b0);
    send_command(KEY_HOME, 1'b0);
    send_command(KEY_ZERO, 1'b0);
    send_command(8'h00, 1'b0);
    send_command(8'hFF, 1'b1);
  endtask

  task automatic test_program_symbols();
    send_command(SYM_PEN_UP, 1'b0);
    send_command(SYM_PEN_DOWN, 1'b0);
    send_command(SYM_TOP, 1'b0);
    send_command(SYM_BOTTOM, 1'b0);
    send_command(SYM_RIGHT, 1'b0);
    send_command(SYM_RIGHT, 1'b0);
    // direction change flushes the R run as its own result
    send_command(SYM_LEFT, 1'b0);
    // flush plus the move itself: two results from one byte
    send_command(SYM_TOP, 1'b0);
    send_command(SYM_RIGHT, 1'b1);
    send_command(SYM_LEFT, 1'b0);
    send_command(KEY_LEFT, 1'b1);
  endtask

  task automatic test_automatic_mode();
    load_settings(5, 20, 6, 48);
    send_command(KEY_ZERO, 1'b0);
    if (trk_manual) send_command(KEY_MODE, 1'b0);
    send_command(KEY_LEFT, 1'b0);
    send_command(SYM_BOTTOM, 1'b0);
    send_command(SYM_TOP, 1'b0);
    send_command(KEY_LIFT, 1'b0);
    send_command(SYM_PEN_UP, 1'b0);
    send_command(KEY_LOWER, 1'b0);
    send_command(SYM_PEN_DOWN, 1'b0);
    send_command(SYM_RIGHT, 1'b0);
    send_command(SYM_RIGHT, 1'b1);
    send_command(KEY_HOME, 1'b0);
    send_command(KEY_MODE, 1'b0);
  endtask

  // Full-length runs hit the run counter limit and drive x past the upper
  // 16-bit rail; home then brings the whole span back in one move
  task automatic test_position_saturation();
    int len;
    load_settings(4095, 63, 63, 255);
    if (!trk_manual) send_command(KEY_MODE, 1'b0);
    send_command(KEY_ZERO, 1'b0);
    for (int r = 0; r < 3; r++) begin
      len = (r < 2) ? MAX_RUN + 1 : 16;
      for (int i = 0; i < len; i++) send_command(SYM_RIGHT, i == len - 1);
    end
    send_command(KEY_HOME, 1'b0);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       load_settings(0, 1, 1, 1);
        1:       load_settings(4095, 63, 63, 255);
        2:       load_settings(int'(RST_MAX_EXTENT), int'(RST_STEP_SCALE),
                               int'(RST_PROGRAM_STEP), int'(RST_LIFT_STEPS));
        default: load_settings($urandom_range(0, 4095), $urandom_range(1, 63),
                               $urandom_range(1, 63), $urandom_range(1, 255));
      endcase
      run_random(110);
    end
  endtask

  // Receiver holds off while the sender keeps offering; input must back up
  task automatic test_output_hold();
    hold_request = 1'b1;
    run_random(40);
  endtask

  task automatic test_unthrottled();
    quiet_mode = 1'b1;
    run_random(90);
  endtask

  initial begin : main
    lim_extent = int'(RST_MAX_EXTENT);
    lim_scale  = int'(RST_STEP_SCALE);
    lim_pstep  = int'(RST_PROGRAM_STEP);
    lim_lift   = int'(RST_LIFT_STEPS);
    trk_x      = 0;
    trk_y      = 0;
    trk_pen    = 0;
    trk_run    = 0;
    trk_manual = 1'b1;
    trk_left   = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_jog_keys();
    test_program_symbols();
    test_automatic_mode();
    test_position_saturation();
    test_random_settings();
    test_output_hold();
    test_unthrottled();
    settle_block();

    if (mismatch_count == 0 && expected_moves.size() == 0) begin
      $display("[plotter_motion_command_interpreter] OK");
    end else begin
      $display("[plotter_motion_command_interpreter] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/pmci_pkg.sv
rtl/pmci_engine.sv
rtl/pmci_steps.sv
rtl/plotter_motion_command_interpreter.sv
dv/plotter_motion_command_interpreter_tb.sv
